### rtl/sed_pkg.sv
package sed_pkg;

   localparam int PIX_W      = 8;
   localparam int CFG_W      = 12;
   localparam int ROW_W      = 12;
   localparam int OUT_COL_W  = 11;
   localparam int OUT_ROW_W  = 11;
   localparam int COUNT_W    = 22;
   localparam int MAX_HEIGHT = 2048;

   // Result tdata layout: col, row, endpoint_count, then zero fill.
   localparam int COL_LSB    = 0;
   localparam int ROW_LSB    = COL_LSB + OUT_COL_W;
   localparam int COUNT_LSB  = ROW_LSB + OUT_ROW_W;
   localparam int RSP_USED_W = COUNT_LSB + COUNT_W;
   localparam int RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_USED_W;

   localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
   localparam logic [PIX_W-1:0]   PIX_FULL     = 8'hff;
   localparam logic [CFG_W-1:0]   WIDTH_RESET  = 12'd640;
   localparam logic [CFG_W-1:0]   HEIGHT_RESET = 12'd480;

   typedef enum logic {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // Per-pixel flags kept in the line store and the window.
   typedef struct packed {
      logic full;
      logic nz;
   } flag_type;

   // Window position of the item, worked out when the item is accepted.
   typedef struct packed {
      logic             valid;
      logic             in_frame;
      logic             top_edge;
      logic             bottom_edge;
      logic             left_edge;
      logic             right_edge;
      logic             done;
      logic [ROW_W-1:0] cr;
   } pos_type;

endpackage

### rtl/skeleton_endpoint_detector_top.sv
// Finds the endpoints of a one-pixel-wide skeleton in an 8-bit image sent
// in raster order, one pixel per item, followed by frame_width+1 padding
// items that flush the last row. A pixel is an endpoint when it is nonzero
// and exactly one of its eight neighbors is 255; positions off the image
// count as zero. Each endpoint gives one result with its column, row and
// the running count (saturating), and the last pixel of the frame always
// gives a result with tlast set, after which the next item opens a new
// frame. The block takes one item per clock when the result side is
// ready. An accepted item is first held in the stage register, with the
// registered line store read beside it, and the window compare then feeds
// the output register. Writing either size register restarts the frame.
module skeleton_endpoint_detector_top
   import sed_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIX_W-1:0]      req_tdata,   // pixel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // col, row, endpoint_count, zero fill
   output logic                  rsp_tuser,   // is_endpoint
   output logic                  rsp_tlast,   // frame_done
   input  logic                  csr_we,
   input  logic [0:0]            csr_index,
   input  logic [CFG_W-1:0]      csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic [CFG_W-1:0] frame_width, frame_height;
   logic             rd_en, s1_valid, s1_adv;
   logic [COL_W-1:0] rd_addr, s1_col, s1_cc;
   flag_type         s1_flag, above, mid;
   pos_type          s1_pos;

   sed_cfg #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_cfg (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index_type'(csr_index)),
      .csr_wdata    (csr_wdata),
      .frame_width  (frame_width),
      .frame_height (frame_height)
   );

   sed_scan #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .restart      (csr_we),
      .frame_width  (frame_width),
      .frame_height (frame_height),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .s1_adv       (s1_adv),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .s1_valid     (s1_valid),
      .s1_col       (s1_col),
      .s1_cc        (s1_cc),
      .s1_flag      (s1_flag),
      .s1_pos       (s1_pos)
   );

   sed_line_buf #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .wr_en   (s1_adv),
      .wr_addr (s1_col),
      .wr_flag (s1_flag),
      .above   (above),
      .mid     (mid)
   );

   sed_window #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_we),
      .s1_valid   (s1_valid),
      .s1_pos     (s1_pos),
      .s1_cc      (s1_cc),
      .s1_flag    (s1_flag),
      .above      (above),
      .mid        (mid),
      .s1_adv     (s1_adv),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Every result reports an endpoint, the end of the frame, or both.
   a_result_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser || rsp_tlast))
      else $error("result carries neither an endpoint nor frame end");

   // A reported endpoint is already included in the count.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[COUNT_LSB +: COUNT_W] != '0))
      else $error("endpoint reported with zero count");

   // An item enters the stage register only when it is free or draining.
   a_stage_free: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> (!s1_valid || s1_adv))
      else $error("item accepted over a stalled stage");

endmodule

### rtl/sed_cfg.sv
module sed_cfg
   import sed_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  csr_index_type    csr_index,
   input  logic [CFG_W-1:0] csr_wdata,
   output logic [CFG_W-1:0] frame_width,
   output logic [CFG_W-1:0] frame_height
);

   localparam logic [CFG_W-1:0] WidthRst =
      (32'(WIDTH_RESET) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : WIDTH_RESET;
   localparam logic [CFG_W-1:0] HeightRst =
      (32'(HEIGHT_RESET) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : HEIGHT_RESET;

   logic [CFG_W-1:0] width_ff, width_in;
   logic [CFG_W-1:0] height_ff, height_in;
   logic [CFG_W-1:0] clamp_w, clamp_h;

   // Sizes are stored already clamped to the supported range.
   always_comb begin
      clamp_w = (csr_wdata == '0) ? CFG_W'(1) :
                (32'(csr_wdata) > MAX_WIDTH) ? CFG_W'(MAX_WIDTH) : csr_wdata;
      clamp_h = (csr_wdata == '0) ? CFG_W'(1) :
                (32'(csr_wdata) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : csr_wdata;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  width_in  = clamp_w;
            CSR_FRAME_HEIGHT: height_in = clamp_h;
            default: begin
               width_in  = width_ff;
               height_in = height_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WidthRst;
         height_ff <= HeightRst;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign frame_width  = width_ff;
   assign frame_height = height_ff;

endmodule

### rtl/sed_scan.sv
module sed_scan
   import sed_pkg::*;
#(
   parameter int MAX_WIDTH = 2048,
   localparam int COL_W = $clog2(MAX_WIDTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             restart,
   input  logic [CFG_W-1:0] frame_width,
   input  logic [CFG_W-1:0] frame_height,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [PIX_W-1:0] req_tdata,
   input  logic             s1_adv,
   output logic             rd_en,
   output logic [COL_W-1:0] rd_addr,
   output logic             s1_valid,
   output logic [COL_W-1:0] s1_col,
   output logic [COL_W-1:0] s1_cc,
   output flag_type         s1_flag,
   output pos_type          s1_pos
);

   logic [COL_W-1:0] col_ff, col_in, c_eff, cc;
   logic [COL_W:0]   col_inc;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [ROW_W:0]   row_x, h_x;
   logic             v1, v2, wrap, accept;
   flag_type         flag;
   pos_type          pos;

   logic             s1_valid_ff, s1_valid_in;
   logic [COL_W-1:0] s1_col_ff, s1_cc_ff;
   flag_type         s1_flag_ff;
   pos_type          s1_pos_ff;

   assign req_tready = !s1_valid_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;

   // The window center trails the input by one row and one pixel. Two
   // cases give a center: the item is past column 0 of row 1 or later
   // (center one up and one left), or it opens row 2 or later (center is
   // the last column two rows up). All edge tests are done on the item's
   // own position so no subtract feeds a compare.
   always_comb begin
      c_eff   = (32'(col_ff) >= 32'(frame_width)) ?
                COL_W'(frame_width - 1'b1) : col_ff;
      col_inc = {1'b0, c_eff} + 1'b1;
      wrap    = 32'(col_inc) >= 32'(frame_width);
      row_x   = {1'b0, row_ff};
      h_x     = {1'b0, frame_height};

      v1 = (c_eff != '0) && (row_ff != '0);
      v2 = (c_eff == '0) && (row_ff >= ROW_W'(2));
      cc = v1 ? (c_eff - 1'b1) : COL_W'(frame_width - 1'b1);

      pos.valid       = v1 || v2;
      pos.cr          = v1 ? (row_ff - ROW_W'(1)) : (row_ff - ROW_W'(2));
      pos.top_edge    = v1 ? (row_ff == ROW_W'(1)) : (row_ff == ROW_W'(2));
      pos.bottom_edge = v1 ? (row_x >= h_x) : (row_x >= h_x + 1'b1);
      pos.in_frame    = v1 ? (row_x < h_x + 1'b1) : (row_x < h_x + 2'd2);
      pos.left_edge   = v1 ? (c_eff == COL_W'(1)) : (frame_width == CFG_W'(1));
      pos.right_edge  = v2;
      pos.done        = v2 && (row_x == h_x + 1'b1);

      flag.nz   = (row_ff < frame_height) && (req_tdata != '0);
      flag.full = (row_ff < frame_height) && (req_tdata == PIX_FULL);

      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (pos.done) begin
            col_in = '0;
            row_in = '0;
         end else if (wrap) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            col_in = col_inc[COL_W-1:0];
         end
      end

      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff  <= c_eff;
         s1_cc_ff   <= cc;
         s1_flag_ff <= flag;
         s1_pos_ff  <= pos;
      end
   end

   assign rd_en    = accept;
   assign rd_addr  = c_eff;
   assign s1_valid = s1_valid_ff;
   assign s1_col   = s1_col_ff;
   assign s1_cc    = s1_cc_ff;
   assign s1_flag  = s1_flag_ff;
   assign s1_pos   = s1_pos_ff;

endmodule

### rtl/sed_line_buf.sv
module sed_line_buf
   import sed_pkg::*;
#(
   parameter int MAX_WIDTH = 2048,
   localparam int COL_W = $clog2(MAX_WIDTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_en,
   input  logic [COL_W-1:0] rd_addr,
   input  logic             wr_en,
   input  logic [COL_W-1:0] wr_addr,
   input  flag_type         wr_flag,
   output flag_type         above,
   output flag_type         mid
);

   // One word per column: the flags of the two rows above the input row.
   typedef struct packed {
      flag_type upper;
      flag_type lower;
   } col_pair_type;

   col_pair_type line_mem [MAX_WIDTH];
   col_pair_type rdata_ff;
   col_pair_type byp_data_ff;
   col_pair_type wr_data;
   col_pair_type cur;
   logic         bypass_ff;

   assign cur           = bypass_ff ? byp_data_ff : rdata_ff;
   assign wr_data.upper = cur.lower;
   assign wr_data.lower = wr_flag;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff    <= line_mem[rd_addr];
         byp_data_ff <= wr_data;
      end
   end

   // With a one-column frame the read of the next item hits the column
   // being written in the same cycle, so the written word is forwarded.
   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff <= 1'b0;
      end else if (rd_en) begin
         bypass_ff <= wr_en && (wr_addr == rd_addr);
      end
   end

   assign above = cur.upper;
   assign mid   = cur.lower;

endmodule

### rtl/sed_window.sv
module sed_window
   import sed_pkg::*;
#(
   parameter int MAX_WIDTH = 2048,
   localparam int COL_W = $clog2(MAX_WIDTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  restart,
   input  logic                  s1_valid,
   input  pos_type               s1_pos,
   input  logic [COL_W-1:0]      s1_cc,
   input  flag_type              s1_flag,
   input  flag_type              above,
   input  flag_type              mid,
   output logic                  s1_adv,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   flag_type win_ff  [3][2];
   flag_type win_in  [3][2];
   flag_type win_now [3][3];
   flag_type new_col [3];
   logic     row_ok  [3];
   logic     col_ok  [3];
   logic [3:0] nb_cnt;
   logic       endpoint, emit, out_free;

   logic [COUNT_W-1:0]   found_ff, found_in, count_res;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_COL_W-1:0] col_ff;
   logic [OUT_ROW_W-1:0] row_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic                 ep_ff, done_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign s1_adv   = s1_valid && out_free;

   assign new_col[0] = above;
   assign new_col[1] = mid;
   assign new_col[2] = s1_flag;

   assign row_ok[0] = !s1_pos.top_edge;
   assign row_ok[1] = 1'b1;
   assign row_ok[2] = !s1_pos.bottom_edge;
   assign col_ok[0] = !s1_pos.left_edge;
   assign col_ok[1] = 1'b1;
   assign col_ok[2] = !s1_pos.right_edge;

   // The window holds only the two newest columns; the third is the
   // column arriving with the item.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         win_now[i][0] = win_ff[i][0];
         win_now[i][1] = win_ff[i][1];
         win_now[i][2] = new_col[i];
         win_in[i][0]  = win_ff[i][1];
         win_in[i][1]  = new_col[i];
      end
   end

   always_comb begin
      nb_cnt = '0;
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            if (!(i == 1 && k == 1)) begin
               nb_cnt = nb_cnt + 4'(win_now[i][k].full && row_ok[i] && col_ok[k]);
            end
         end
      end
   end

   always_comb begin
      endpoint  = s1_pos.valid && s1_pos.in_frame && win_now[1][1].nz &&
                  (nb_cnt == 4'd1);
      emit      = s1_pos.valid && (endpoint || s1_pos.done);
      count_res = (endpoint && (found_ff != COUNT_MAX)) ?
                  (found_ff + 1'b1) : found_ff;

      found_in = found_ff;
      if (restart) begin
         found_in = '0;
      end else if (s1_adv && s1_pos.valid) begin
         found_in = s1_pos.done ? '0 : count_res;
      end

      if (out_free) begin
         rsp_valid_in = s1_valid && emit;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= '0;
            win_ff[i][1] <= '0;
         end
      end else begin
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_adv) begin
            win_ff <= win_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && emit) begin
         col_ff   <= OUT_COL_W'(s1_cc);
         row_ff   <= OUT_ROW_W'(s1_pos.cr);
         count_ff <= count_res;
         ep_ff    <= endpoint;
         done_ff  <= s1_pos.done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, count_ff, row_ff, col_ff};
   assign rsp_tuser  = ep_ff;
   assign rsp_tlast  = done_ff;

endmodule

### test/tb.sv
module tb;
   import sed_pkg::*;

   localparam int MAX_W       = 2048;
   localparam int HOLD_CYCLES = 200;
   localparam int DRAIN_SLACK = 8;
   localparam int ITEM_TARGET = 340;

   typedef struct packed {
      logic [OUT_COL_W-1:0] col;
      logic [OUT_ROW_W-1:0] row;
      logic                 is_end;
      logic [COUNT_W-1:0]   count;
      logic                 done;
   } report_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [PIX_W-1:0]      req_tdata  = '0;   // pixel
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // col, row, endpoint_count, zero fill
   logic                  rsp_tuser;         // is_endpoint
   logic                  rsp_tlast;         // frame_done
   logic                  csr_we     = 1'b0;
   logic [0:0]            csr_index  = '0;
   logic [CFG_W-1:0]      csr_wdata  = '0;

   // Shadow of the detector state, kept in step with accepted items.
   logic [CFG_W-1:0]     cfg_width  = WIDTH_RESET;
   logic [CFG_W-1:0]     cfg_height = HEIGHT_RESET;
   flag_type             line_mem [2*MAX_W] = '{default: '0};
   flag_type             win [3][3] = '{default: '0};
   logic [OUT_COL_W-1:0] cur_col = '0;
   logic [ROW_W-1:0]     cur_row = '0;
   logic [COUNT_W-1:0]   found   = '0;

   report_type       expected_reports [$];
   logic [PIX_W-1:0] frame_pixels [$];

   int mismatches     = 0;
   int pixels_sent    = 0;
   int frames_seen    = 0;
   int endpoints_seen = 0;
   int holds_asked    = 0;
   int holds_served   = 0;
   bit calm           = 1'b0;

   skeleton_endpoint_detector_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic int eff_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > MAX_W) return MAX_W;
      return cfg_width;
   endfunction

   function automatic int eff_height();
      if (cfg_height == 0) return 1;
      if (cfg_height > MAX_HEIGHT) return MAX_HEIGHT;
      return cfg_height;
   endfunction

   function automatic void restart_frame();
      cur_col = '0;
      cur_row = '0;
      found   = '0;
   endfunction

   // Advances the shadow by one item and returns 1 when the item yields a report.
   // The window center trails the input by one row and one column.
   function automatic bit scan_pixel(input logic [PIX_W-1:0] pix, output report_type rep);
      int       w, h, c, r, cc, cr, nb;
      flag_type cur, above, mid;
      bit       seen, is_end, done;
      w    = eff_width();
      h    = eff_height();
      c    = cur_col;
      r    = cur_row;
      rep  = '0;
      cur  = '0;
      seen = 1'b0;
      cc   = 0;
      cr   = 0;
      nb   = 0;
      if (c >= w) c = w - 1;
      if (r < h) begin
         cur.nz   = (pix != 0);
         cur.full = (pix == PIX_FULL);
      end
      above = line_mem[MAX_W + c];
      mid   = line_mem[c];
      line_mem[MAX_W + c] = mid;
      line_mem[c]         = cur;
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = above;
      win[1][2] = mid;
      win[2][2] = cur;
      if (c >= 1 && r >= 1) begin
         seen = 1'b1;
         cc   = c - 1;
         cr   = r - 1;
      end else if (c == 0 && r >= 2) begin
         seen = 1'b1;
         cc   = w - 1;
         cr   = r - 2;
      end
      if (c + 1 >= w) begin
         cur_col = '0;
         cur_row = cur_row + 1'b1;
      end else begin
         cur_col = OUT_COL_W'(c + 1);
      end
      if (!seen) return 1'b0;
      for (int i = 0; i < 3; i++)
         for (int k = 0; k < 3; k++)
            if (!(i == 1 && k == 1) && !(i == 0 && cr == 0) && !(i == 2 && cr >= h - 1) &&
                !(k == 0 && cc == 0) && !(k == 2 && cc >= w - 1) && win[i][k].full)
               nb++;
      is_end = (cr < h) && win[1][1].nz && (nb == 1);
      done   = (cr == h - 1) && (cc == w - 1);
      if (is_end && found != COUNT_MAX) found = found + 1'b1;
      if (!is_end && !done) return 1'b0;
      rep.col    = OUT_COL_W'(cc);
      rep.row    = OUT_ROW_W'(cr);
      rep.is_end = is_end;
      rep.count  = found;
      rep.done   = done;
      if (done) restart_frame();
      return 1'b1;
   endfunction

   function automatic logic [PIX_W-1:0] noise_pixel();
      int pick = $urandom_range(0, 19);
      if (pick < 13) return '0;
      if (pick < 17) return PIX_FULL;
      return PIX_W'($urandom_range(1, 254));
   endfunction

   // Style 0 is scattered noise, 1 is short random strokes, 2 is rows of
   // two-pixel segments that make almost every lit pixel an endpoint.
   function automatic void make_image(input int w, input int h, input int style);
      int x, y;
      frame_pixels.delete();
      for (int i = 0; i < w * h; i++)
         frame_pixels.insert(frame_pixels.size(), (style == 0) ? noise_pixel() : PIX_W'(0));
      if (style == 1) begin
         repeat (1 + w * h / 12) begin
            x = $urandom_range(0, w - 1);
            y = $urandom_range(0, h - 1);
            repeat ($urandom_range(1, 8)) begin
               frame_pixels[y * w + x] = ($urandom_range(0, 9) == 0) ?
                                         PIX_W'($urandom_range(1, 254)) : PIX_FULL;
               x += int'($urandom_range(0, 2)) - 1;
               y += int'($urandom_range(0, 2)) - 1;
               if (x < 0) x = 0;
               if (x >= w) x = w - 1;
               if (y < 0) y = 0;
               if (y >= h) y = h - 1;
            end
         end
      end else if (style == 2) begin
         for (int yy = 0; yy < h; yy += 2)
            for (int xx = 0; xx < w; xx++)
               if (xx % 3 != 2)
                  frame_pixels[yy * w + xx] = ($urandom_range(0, 3) == 0) ?
                                              PIX_W'($urandom_range(1, 254)) : PIX_FULL;
      end
   endfunction

   task automatic send_pixel(input logic [PIX_W-1:0] pix);
      report_type rep;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      do @(posedge clock); while (!req_tready);
      pixels_sent++;
      if (scan_pixel(pix, rep)) expected_reports.insert(expected_reports.size(), rep);
   endtask

   // A negative cut sends the whole frame and its padding; otherwise only the
   // first cut pixels go out and the frame is left unfinished.
   task automatic send_frame(input int cut);
      int n;
      n = (cut < 0) ? frame_pixels.size() : cut;
      for (int i = 0; i < n; i++) send_pixel(frame_pixels[i]);
      if (cut < 0)
         for (int i = 0; i <= eff_width(); i++)
            send_pixel($urandom_range(0, 1) ? PIX_FULL : PIX_W'($urandom_range(0, 255)));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CFG_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CSR_FRAME_WIDTH) cfg_width = val;
      else cfg_height = val;
      restart_frame();
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
   endtask

   task automatic test_directed();
      set_size(12'd3, 12'd3);
      frame_pixels = {8'd255, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd254};
      send_frame(-1);
      wait_idle();
      // Zero sizes clamp to a single pixel.
      set_size(12'd0, 12'd0);
      frame_pixels = {8'd255};
      send_frame(-1);
      wait_idle();
      // Both pixels are endpoints, and the second also closes the frame.
      set_size(12'd2, 12'd1);
      frame_pixels = {8'd255, 8'd255};
      send_frame(-1);
      wait_idle();
   endtask

   // Oversized registers clamp to the largest frame; only the first part of
   // each frame goes out so the run stays short.
   task automatic test_sizes();
      set_size(12'hfff, 12'd2);
      make_image(eff_width(), eff_height(), 1);
      send_frame(40);
      wait_idle();
      set_size(12'd1, 12'hfff);
      make_image(eff_width(), eff_height(), 1);
      send_frame(60);
      wait_idle();
   endtask

   task automatic test_restart();
      set_size(12'd5, 12'd4);
      make_image(5, 4, 1);
      send_frame(11);
      wait_idle();
      write_reg(CSR_FRAME_WIDTH, 12'd5);
      make_image(5, 4, 1);
      send_frame(-1);
      make_image(5, 4, 0);
      send_frame(7);
      wait_idle();
      write_reg(CSR_FRAME_HEIGHT, 12'd4);
      make_image(5, 4, 0);
      send_frame(-1);
      wait_idle();
   endtask

   task automatic test_backpressure();
      set_size(12'd12, 12'd6);
      make_image(12, 6, 2);
      holds_asked++;
      send_frame(-1);
      wait_idle();
   endtask

   task automatic test_random();
      int stop_at, w, h;
      bit fresh;
      stop_at = pixels_sent + ITEM_TARGET;
      w       = 1;
      h       = 1;
      fresh   = 1'b1;
      while (pixels_sent < stop_at) begin
         if (fresh || $urandom_range(0, 2) == 0) begin
            wait_idle();
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 16);
            h = $urandom_range(1, 10);
            set_size(CFG_W'(w), CFG_W'(h));
            fresh = 1'b0;
         end
         make_image(w, h, $urandom_range(0, 1));
         if ($urandom_range(0, 9) == 0) begin
            // An abandoned frame; rewriting a size register starts over.
            send_frame($urandom_range(0, w * h - 1));
            wait_idle();
            write_reg(CSR_FRAME_HEIGHT, cfg_height);
         end else begin
            send_frame(-1);
         end
      end
      wait_idle();
   endtask

   task automatic test_calm();
      calm = 1'b1;
      set_size(12'd9, 12'd7);
      repeat (3) begin
         make_image(9, 7, $urandom_range(0, 2));
         send_frame(-1);
      end
      wait_idle();
   endtask

   // Result side ready: random stalls unless calm, plus one long hold when a test asks.
   always begin
      @(posedge clock);
      if (holds_asked != holds_served) begin
         rsp_tready <= 1'b0;
         repeat (HOLD_CYCLES) @(posedge clock);
         holds_served++;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      report_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.col    = rsp_tdata[COL_LSB +: OUT_COL_W];
         got.row    = rsp_tdata[ROW_LSB +: OUT_ROW_W];
         got.is_end = rsp_tuser;
         got.count  = rsp_tdata[COUNT_LSB +: COUNT_W];
         got.done   = rsp_tlast;
         if (got.done) frames_seen++;
         if (got.is_end) endpoints_seen++;
         if (expected_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: col %0d row %0d end %0b count %0d done %0b",
                        got.col, got.row, got.is_end, got.count, got.done);
         end else begin
            want = expected_reports.pop_front();
            if (got.col !== want.col || got.row !== want.row || got.is_end !== want.is_end ||
                got.count !== want.count || got.done !== want.done) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected col %0d row %0d end %0b count %0d done %0b, %s",
                           want.col, want.row, want.is_end, want.count, want.done,
                           $sformatf("got col %0d row %0d end %0b count %0d done %0b",
                                     got.col, got.row, got.is_end, got.count, got.done));
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_sizes();
      test_restart();
      test_backpressure();
      test_random();
      test_calm();
      $display("summary: %0d pixels sent, %0d endpoint reports and %0d frame ends checked",
               pixels_sent, endpoints_seen, frames_seen);
      $display("summary: small directed frames, clamped sizes, restarts, a long stall, random");
      if (mismatches == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("tb: errors");
      $finish;
   end

endmodule

### filelist.f
rtl/sed_pkg.sv
rtl/sed_cfg.sv
rtl/sed_scan.sv
rtl/sed_line_buf.sv
rtl/sed_window.sv
rtl/skeleton_endpoint_detector_top.sv
test/tb.sv
